// File: hw/rtl/prqs_pkg.sv
`default_nettype none
package prqs_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int KIND_W   = 2;
    localparam int ID_W     = 4;
    localparam int PRIO_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 3;
    localparam int TICK_W   = 32;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCHED  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic latch;
        logic exec;
        logic reins;
    } prqs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic reins_needed;
    } prqs_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/priority_ready_queue_scheduler_top.sv
// result: done pulses in the response state, after the execute step or, for a
//   schedule or tick that preempts a running task, after the re-insert step
//   (pop, then re-insert by priority); throughput: one transaction at a time
//   and one queue shift (insert or remove) per cycle; results cannot be stalled
// reset: async active low; empties queue and running slot, zeroes tick count
`default_nettype none
module priority_ready_queue_scheduler_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [prqs_pkg::KIND_W-1:0]   kind,
    input  wire logic [prqs_pkg::ID_W-1:0]     task_id,
    input  wire logic [prqs_pkg::PRIO_W-1:0]   priority_req,
    output logic                               done,
    output logic      [prqs_pkg::ID_W-1:0]     running_task,
    output logic                               running_valid,
    output logic      [prqs_pkg::COUNT_W-1:0]  ready_count,
    output logic      [prqs_pkg::STATUS_W-1:0] status,
    output logic      [prqs_pkg::TICK_W-1:0]   tick_count
);
    import prqs_pkg::*;

    prqs_cmd_t cmd;
    prqs_sts_t sts;

    // sequencer
    prqs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // queue and running slot
    prqs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .task_id       (task_id),
        .priority_req  (priority_req),
        .running_task  (running_task),
        .running_valid (running_valid),
        .ready_count   (ready_count),
        .status        (status),
        .tick_count    (tick_count)
    );

endmodule
`default_nettype wire

// File: hw/rtl/prqs_datapath.sv
`default_nettype none
module prqs_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire prqs_pkg::prqs_cmd_t           cmd,
    output prqs_pkg::prqs_sts_t                sts,
    input  wire logic [prqs_pkg::KIND_W-1:0]   kind,
    input  wire logic [prqs_pkg::ID_W-1:0]     task_id,
    input  wire logic [prqs_pkg::PRIO_W-1:0]   priority_req,
    output logic      [prqs_pkg::ID_W-1:0]     running_task,
    output logic                               running_valid,
    output logic      [prqs_pkg::COUNT_W-1:0]  ready_count,
    output logic      [prqs_pkg::STATUS_W-1:0] status,
    output logic      [prqs_pkg::TICK_W-1:0]   tick_count
);
    import prqs_pkg::*;

    // latched transaction
    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PRIO_W-1:0] prio_reg;

    // sorted ready queue, head at entry 0
    logic [ID_W-1:0]   q_id_reg   [QUEUE_DEPTH];
    logic [PRIO_W-1:0] q_prio_reg [QUEUE_DEPTH];
    logic [ID_W-1:0]   q_id_next  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] q_prio_next[QUEUE_DEPTH];
    logic [LEN_W-1:0]  len_reg, len_next;

    // running slot and counters
    logic [ID_W-1:0]     run_id_reg, run_id_next;
    logic [PRIO_W-1:0]   run_prio_reg, run_prio_next;
    logic                run_valid_reg, run_valid_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // preempted task waiting for re-insertion
    logic [ID_W-1:0]   hold_id_reg, hold_id_next;
    logic [PRIO_W-1:0] hold_prio_reg, hold_prio_next;

    // per-entry compare results
    logic [QUEUE_DEPTH-1:0] occ;
    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] ge;
    logic [QUEUE_DEPTH-1:0] first_lt;
    logic [QUEUE_DEPTH-1:0] rem_prefix;
    logic [QUEUE_DEPTH-1:0] rem_mask;

    logic [ID_W-1:0]   ins_id;
    logic [PRIO_W-1:0] ins_prio;
    logic              run_hit;
    logic              found;
    logic              q_empty;
    logic              pop_req;
    logic              do_ins;
    logic              do_rem;

    // insertion source: new task on create, preempted task on re-insert
    assign ins_id   = cmd.reins ? hold_id_reg : id_reg;
    assign ins_prio = cmd.reins ? hold_prio_reg : prio_reg;
    assign run_hit  = run_valid_reg && (run_id_reg == id_reg);
    assign q_empty  = (len_reg == '0);

    // entry compares
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            occ[i]   = (LEN_W'(i) < len_reg);
            match[i] = occ[i] && (q_id_reg[i] == id_reg);
            ge[i]    = occ[i] && (q_prio_reg[i] >= ins_prio);
        end
        first_lt = ~ge & {ge[QUEUE_DEPTH-2:0], 1'b1};
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            rem_prefix[i] = 1'b0;
            for (int j = 0; j <= i; j++)
            begin
                rem_prefix[i] = rem_prefix[i] | match[j];
            end
        end
    end

    assign found = |match;

    // operation decode and next state
    always_comb
    begin
        len_next       = len_reg;
        run_id_next    = run_id_reg;
        run_prio_next  = run_prio_reg;
        run_valid_next = run_valid_reg;
        ticks_next     = ticks_reg;
        status_next    = status_reg;
        hold_id_next   = hold_id_reg;
        hold_prio_next = hold_prio_reg;
        pop_req        = 1'b0;
        do_ins         = 1'b0;
        do_rem         = 1'b0;
        rem_mask       = rem_prefix;

        if (cmd.exec)
        begin
            status_next = ST_OK;
            case (kind_reg)
                KIND_CREATE:
                begin
                    if (found || run_hit)
                    begin
                        status_next = ST_DUP;
                    end
                    else if (len_reg >= LEN_W'(QUEUE_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        do_ins   = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                KIND_DELETE:
                begin
                    if (run_hit)
                    begin
                        run_valid_next = 1'b0;
                    end
                    else if (found)
                    begin
                        do_rem   = 1'b1;
                        len_next = len_reg - LEN_W'(1);
                    end
                    else
                    begin
                        status_next = ST_MISSING;
                    end
                end
                KIND_SCHED:
                begin
                    pop_req = 1'b1;
                end
                default:
                begin
                    ticks_next = ticks_reg + TICK_W'(1);
                    pop_req    = run_valid_reg;
                end
            endcase

            // pop head into the running slot, park the old one
            if (pop_req)
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_rem         = 1'b1;
                    rem_mask       = '1;
                    len_next       = len_reg - LEN_W'(1);
                    run_id_next    = q_id_reg[0];
                    run_prio_next  = q_prio_reg[0];
                    run_valid_next = 1'b1;
                    hold_id_next   = run_id_reg;
                    hold_prio_next = run_prio_reg;
                end
            end
        end

        if (cmd.reins)
        begin
            do_ins   = 1'b1;
            len_next = len_reg + LEN_W'(1);
        end
    end

    // queue shift network: insert shifts up, remove shifts down
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_id_next[i]   = q_id_reg[i];
            q_prio_next[i] = q_prio_reg[i];
        end
        if (do_ins)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (first_lt[i])
                begin
                    q_id_next[i]   = ins_id;
                    q_prio_next[i] = ins_prio;
                end
                else if (!ge[i])
                begin
                    q_id_next[i]   = q_id_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                    q_prio_next[i] = q_prio_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                end
            end
        end
        else if (do_rem)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (rem_mask[i])
                begin
                    q_id_next[i]   = q_id_reg[i + 1];
                    q_prio_next[i] = q_prio_reg[i + 1];
                end
            end
        end
    end

    assign sts.reins_needed = cmd.exec && pop_req && !q_empty && run_valid_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            run_id_reg    <= '0;
            run_prio_reg  <= '0;
            run_valid_reg <= 1'b0;
            ticks_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            len_reg       <= len_next;
            run_id_reg    <= run_id_next;
            run_prio_reg  <= run_prio_next;
            run_valid_reg <= run_valid_next;
            ticks_reg     <= ticks_next;
            status_reg    <= status_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind;
            id_reg   <= task_id;
            prio_reg <= priority_req;
        end
        hold_id_reg   <= hold_id_next;
        hold_prio_reg <= hold_prio_next;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_id_reg[i]   <= q_id_next[i];
            q_prio_reg[i] <= q_prio_next[i];
        end
    end

    // result fields
    assign running_task  = run_valid_reg ? run_id_reg : '0;
    assign running_valid = run_valid_reg;
    assign ready_count   = COUNT_W'(len_reg);
    assign status        = status_reg;
    assign tick_count    = ticks_reg;

    // queue never overfills
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(QUEUE_DEPTH))
        else $error("ready queue length above depth");

    // a successful create grows the queue by one
    a_create_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (kind_reg == KIND_CREATE) && (status_next == ST_OK)
        |=> len_reg == $past(len_reg) + LEN_W'(1))
        else $error("create did not grow ready queue");

    // re-insert only happens with a task running and room in the queue
    a_reins_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reins |-> run_valid_reg && (len_reg < LEN_W'(QUEUE_DEPTH)))
        else $error("re-insert without running task or room");

endmodule
`default_nettype wire

// File: hw/rtl/prqs_ctrl.sv
`default_nettype none
module prqs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire prqs_pkg::prqs_sts_t  sts,
    output prqs_pkg::prqs_cmd_t       cmd,
    output logic                      busy,
    output logic                      done
);
    import prqs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_REINS = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0] state_reg, state_next;

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = sts.reins_needed ? S_REINS : S_RESP;
            end
            S_REINS:
            begin
                state_next = S_RESP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // command decode
    assign cmd.latch = (state_reg == S_IDLE) && start;
    assign cmd.exec  = (state_reg == S_EXEC);
    assign cmd.reins = (state_reg == S_REINS);
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_RESP);

    // a result always follows an execute or re-insert step
    a_done_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_EXEC) || ($past(state_reg) == S_REINS))
        else $error("result strobe out of sequence");

endmodule
`default_nettype wire

// File: bench/priority_ready_queue_scheduler_top_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module priority_ready_queue_scheduler_top_tb;

    import prqs_pkg::*;

    // one scheduler outcome as seen on the result ports
    typedef struct packed {
        logic [ID_W-1:0]     running_task;
        logic                running_valid;
        logic [COUNT_W-1:0]  ready_count;
        logic [STATUS_W-1:0] status;
        logic [TICK_W-1:0]   tick_count;
    } sched_outcome_t;

    // mirror of the ready queue and running slot, plus the outcomes still owed
    class sched_scoreboard;
        logic [ID_W-1:0]   ready_ids[QUEUE_DEPTH];
        logic [PRIO_W-1:0] ready_prios[QUEUE_DEPTH];
        int                ready_len;
        logic [ID_W-1:0]   run_id;
        logic [PRIO_W-1:0] run_prio;
        bit                run_on;
        logic [TICK_W-1:0] ticks;
        sched_outcome_t    outcomes_due[$];
        int                errors;

        function new();
            ready_len = 0;
            run_id    = '0;
            run_prio  = '0;
            run_on    = 1'b0;
            ticks     = '0;
            errors    = 0;
        endfunction

        function int locate(logic [ID_W-1:0] id);
            for (int i = 0; i < ready_len; i++)
                if (ready_ids[i] == id)
                    return i;
            return -1;
        endfunction

        // behind every entry of equal or higher priority
        function void enqueue_by_priority(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
            int pos;
            pos = 0;
            while (pos < ready_len && ready_prios[pos] >= prio)
                pos++;
            for (int i = ready_len; i > pos; i--)
            begin
                ready_ids[i]   = ready_ids[i-1];
                ready_prios[i] = ready_prios[i-1];
            end
            ready_ids[pos]   = id;
            ready_prios[pos] = prio;
            ready_len++;
        endfunction

        function void drop_at(int pos);
            for (int i = pos; i + 1 < ready_len; i++)
            begin
                ready_ids[i]   = ready_ids[i+1];
                ready_prios[i] = ready_prios[i+1];
            end
            ready_len--;
        endfunction

        // pop the head into the running slot, preempted task goes back by priority
        function logic [STATUS_W-1:0] dispatch_head();
            logic [ID_W-1:0]   head_id;
            logic [PRIO_W-1:0] head_prio;
            if (ready_len == 0)
                return ST_EMPTY;
            head_id   = ready_ids[0];
            head_prio = ready_prios[0];
            drop_at(0);
            if (run_on)
                enqueue_by_priority(run_id, run_prio);
            run_id   = head_id;
            run_prio = head_prio;
            run_on   = 1'b1;
            return ST_OK;
        endfunction

        // accepted transaction: update the mirror and queue the outcome
        function void note_command(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                   logic [PRIO_W-1:0] prio);
            logic [STATUS_W-1:0] st;
            sched_outcome_t      exp_out;
            st = ST_OK;
            case (k)
                KIND_CREATE:
                begin
                    if (locate(id) >= 0 || (run_on && run_id == id))
                        st = ST_DUP;
                    else if (ready_len >= QUEUE_DEPTH)
                        st = ST_FULL;
                    else
                        enqueue_by_priority(id, prio);
                end
                KIND_DELETE:
                begin
                    if (run_on && run_id == id)
                    begin
                        run_on   = 1'b0;
                        run_id   = '0;
                        run_prio = '0;
                    end
                    else if (locate(id) < 0)
                        st = ST_MISSING;
                    else
                        drop_at(locate(id));
                end
                KIND_SCHED:
                    st = dispatch_head();
                default:
                begin
                    ticks = ticks + 1;
                    if (run_on)
                        st = dispatch_head();
                end
            endcase
            exp_out.running_task  = run_on ? run_id : '0;
            exp_out.running_valid = run_on;
            exp_out.ready_count   = ready_len[COUNT_W-1:0];
            exp_out.status        = st;
            exp_out.tick_count    = ticks;
            outcomes_due.push_back(exp_out);
        endfunction

        // compare a strobed outcome with the oldest one owed
        function void check_outcome(sched_outcome_t got);
            sched_outcome_t exp_out;
            if (outcomes_due.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            exp_out = outcomes_due.pop_front();
            if (got.running_task !== exp_out.running_task)
            begin
                $error("running_task: expected %0d, got %0d",
                       exp_out.running_task, got.running_task);
                errors++;
            end
            if (got.running_valid !== exp_out.running_valid)
            begin
                $error("running_valid: expected %0d, got %0d",
                       exp_out.running_valid, got.running_valid);
                errors++;
            end
            if (got.ready_count !== exp_out.ready_count)
            begin
                $error("ready_count: expected %0d, got %0d",
                       exp_out.ready_count, got.ready_count);
                errors++;
            end
            if (got.status !== exp_out.status)
            begin
                $error("status: expected %0d, got %0d", exp_out.status, got.status);
                errors++;
            end
            if (got.tick_count !== exp_out.tick_count)
            begin
                $error("tick_count: expected %0d, got %0d",
                       exp_out.tick_count, got.tick_count);
                errors++;
            end
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic [KIND_W-1:0]   kind         = KIND_SCHED;
    logic [ID_W-1:0]     task_id      = '0;
    logic [PRIO_W-1:0]   priority_req = '0;
    logic                busy;
    logic                done;
    logic [ID_W-1:0]     running_task;
    logic                running_valid;
    logic [COUNT_W-1:0]  ready_count;
    logic [STATUS_W-1:0] status;
    logic [TICK_W-1:0]   tick_count;

    sched_scoreboard sb = new();

    priority_ready_queue_scheduler_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .task_id       (task_id),
        .priority_req  (priority_req),
        .done          (done),
        .running_task  (running_task),
        .running_valid (running_valid),
        .ready_count   (ready_count),
        .status        (status),
        .tick_count    (tick_count)
    );

    always #5 clk = ~clk;

    // result monitor: outcome is valid for the cycle ending at this edge
    always @(posedge clk)
    begin
        sched_outcome_t got;
        if (rst_n && done)
        begin
            got.running_task  = running_task;
            got.running_valid = running_valid;
            got.ready_count   = ready_count;
            got.status        = status;
            got.tick_count    = tick_count;
            sb.check_outcome(got);
        end
    end

    // present one transaction, hold until accepted, then sometimes idle with start low
    task automatic issue_command(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                                 input logic [PRIO_W-1:0] prio, input bit allow_idle);
        start        <= 1'b1;
        kind         <= k;
        task_id      <= id;
        priority_req <= prio;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(k, id, prio);
        if (allow_idle && $urandom_range(0, 99) < 26)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // run limit
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [KIND_W-1:0] k;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        bit                filling;
        int                roll;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, missing id, duplicates, ties, head insert, preemption
        issue_command(KIND_SCHED,  4'd9,  8'd77,  1'b1);
        issue_command(KIND_TICK,   4'd1,  8'd200, 1'b1);
        issue_command(KIND_DELETE, 4'd5,  8'd255, 1'b1);
        issue_command(KIND_CREATE, 4'd3,  8'd10,  1'b1);
        issue_command(KIND_CREATE, 4'd3,  8'd200, 1'b1);
        issue_command(KIND_CREATE, 4'd7,  8'd10,  1'b1);
        issue_command(KIND_CREATE, 4'd12, 8'd255, 1'b1);
        issue_command(KIND_CREATE, 4'd0,  8'd0,   1'b1);
        issue_command(KIND_CREATE, 4'd15, 8'd10,  1'b1);
        issue_command(KIND_SCHED,  4'd0,  8'd0,   1'b1);
        issue_command(KIND_CREATE, 4'd12, 8'd1,   1'b1);
        issue_command(KIND_TICK,   4'd15, 8'd255, 1'b1);
        issue_command(KIND_TICK,   4'd0,  8'd0,   1'b1);
        issue_command(KIND_DELETE, 4'd7,  8'd0,   1'b1);
        issue_command(KIND_DELETE, 4'd12, 8'd255, 1'b1);
        issue_command(KIND_SCHED,  4'd15, 8'd255, 1'b1);
        issue_command(KIND_SCHED,  4'd0,  8'd0,   1'b1);
        issue_command(KIND_DELETE, 4'd0,  8'd0,   1'b1);
        issue_command(KIND_DELETE, 4'd15, 8'd0,   1'b1);
        issue_command(KIND_TICK,   4'd0,  8'd0,   1'b1);
        issue_command(KIND_SCHED,  4'd0,  8'd0,   1'b1);
        issue_command(KIND_CREATE, 4'd9,  8'd255, 1'b1);
        issue_command(KIND_DELETE, 4'd3,  8'd0,   1'b1);

        // random: alternate filling and draining phases to reach a full queue and back
        filling = 1'b1;
        for (int n = 0; n < 950; n++)
        begin
            if (n % 50 == 0)
                filling = (n % 100 == 0);
            roll = $urandom_range(0, 99);
            if (filling)
                k = (roll < 55) ? KIND_CREATE : (roll < 70) ? KIND_DELETE :
                    (roll < 85) ? KIND_SCHED : KIND_TICK;
            else
                k = (roll < 20) ? KIND_CREATE : (roll < 60) ? KIND_DELETE :
                    (roll < 80) ? KIND_SCHED : KIND_TICK;
            id = ID_W'($urandom_range(0, 15));
            // deleting the running task frees an id for the queue
            if (k == KIND_DELETE && sb.run_on && $urandom_range(0, 99) < 40)
                id = sb.run_id;
            // a few favorite priorities force ties
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 3))
                    0:       prio = 8'd0;
                    1:       prio = 8'd255;
                    2:       prio = 8'd128;
                    default: prio = 8'd7;
                endcase
            end
            else
                prio = PRIO_W'($urandom_range(0, 255));
            issue_command(k, id, prio, !(n >= 400 && n < 550));
        end
        start <= 1'b0;

        // drain outstanding outcomes, then wait for stray strobes
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
